// ===== hw/rtl/fbfa_pkg.sv =====
// shared types and constants of the fixed block free-list allocator
`timescale 1ns / 1ps

package fbfa_pkg;

    // fixed field widths
    localparam int CNT_W     = 9;
    localparam int BYTES_W   = 16;
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int GRANT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    // wide enough for any block index, count or null marker compare
    localparam int CMP_W     = 17;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ALLOC    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE     = 2'd1;
    localparam logic [FUNC_W-1:0] FN_TEARDOWN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd1;

    // register reset values
    localparam logic [CNT_W-1:0]   BLOCK_COUNT_RST = 9'd256;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOBLOCK  = 3'd1,
        ST_BADSTATE = 3'd2,
        ST_NOTOWNER = 3'd3,
        ST_INUSE    = 3'd4
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [BYTES_W-1:0] request_bytes;
        logic [IDX_W-1:0]   free_index;
    } t_req_beat;

    typedef struct packed {
        t_status            status;
        logic [GRANT_W-1:0] granted_index;
    } t_rsp_beat;

endpackage

// ===== hw/rtl/fbfa_req_if.sv =====
// request channel: valid/ready handshake carrying one operation beat
`timescale 1ns / 1ps

interface fbfa_req_if;
    import fbfa_pkg::*;

    logic      valid;
    logic      ready;
    t_req_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fbfa_rsp_if.sv =====
// response channel: valid/ready handshake carrying one result beat
`timescale 1ns / 1ps

interface fbfa_rsp_if;
    import fbfa_pkg::*;

    logic      valid;
    logic      ready;
    t_rsp_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fbfa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module fbfa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/fixed_block_free_list_allocator.sv =====
// top level: fixed-size block allocator with a lifo free list in a link ram
`timescale 1ns / 1ps
// free, and any refused operation that runs no set-up: goes to the done state, then the output slot.
// allocate from a set-up pool: reads the head link, then done; an allocate that runs set-up
// writes one link ram entry a cycle for each live block, the last one settling the grant.
// teardown: walks the free list in check and read steps, one link ram read per step.
// one operation at a time; reset clears the pool, the head and the registers,
// the link ram is not cleared and is written by set-up before any read.
module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fbfa_req_if.sink                          i_req,
    fbfa_rsp_if.source                        o_rsp,
    input  logic                              i_cfg_we,
    input  logic [fbfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fbfa_pkg::CFG_DAT_W-1:0]    i_cfg_data
);
    import fbfa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0]    NULL_LINK = LW'(MAX_BLOCKS);
    localparam logic [CMP_W-1:0] MAX_WIDE  = CMP_W'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ALLOC,
        S_WALK_CHK,
        S_WALK_RD,
        S_DONE
    } t_state;

    t_state              r_state,       n_state;
    logic                r_pool_ready,  n_pool_ready;
    logic [LW-1:0]       r_head,        n_head;
    logic [LW-1:0]       r_cur,         n_cur;
    logic [CNT_W-1:0]    r_cnt,         n_cnt;
    logic [CNT_W-1:0]    r_seen,        n_seen;
    logic [BYTES_W-1:0]  r_req,         n_req;
    t_rsp_beat           r_res,         n_res;
    logic                r_out_valid,   n_out_valid;
    t_rsp_beat           r_out_data,    n_out_data;
    logic [CNT_W-1:0]    r_block_count;
    logic [BYTES_W-1:0]  r_block_bytes;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [LW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [LW-1:0]       ram_rdata;

    logic                in_acc;
    logic [CNT_W-1:0]    live;
    logic                head_null;
    logic                cur_null;
    logic                setup_last;
    logic                idx_oor;

    // link memory
    fbfa_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake and derived conditions
    assign in_acc      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    assign live = ({8'd0, r_block_count} > MAX_WIDE) ? MAX_WIDE[CNT_W-1:0] : r_block_count;
    assign head_null  = (r_head >= NULL_LINK);
    assign cur_null   = (r_cur >= NULL_LINK);
    assign setup_last = ((r_cnt + 9'd1) >= live);
    assign idx_oor    = ({1'b0, i_req.data.free_index} >= {8'd0, live});

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= BLOCK_COUNT_RST;
            r_block_bytes <= BLOCK_BYTES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[CNT_W-1:0];
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer next-state logic
    always_comb begin
        n_state      = r_state;
        n_pool_ready = r_pool_ready;
        n_head       = r_head;
        n_cur        = r_cur;
        n_cnt        = r_cnt;
        n_seen       = r_seen;
        n_req        = r_req;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = r_head[AW-1:0];

        // output slot drains when taken
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req               = i_req.data.request_bytes;
                    n_res.granted_index = '0;
                    n_res.status        = ST_BADSTATE;
                    n_state             = S_DONE;
                    case (i_req.data.func)
                        FN_ALLOC: begin
                            if (!r_pool_ready) begin
                                if (live != '0 && r_block_bytes != '0) begin
                                    n_cnt   = '0;
                                    n_state = S_SETUP;
                                end
                            end else if (head_null ||
                                         i_req.data.request_bytes > r_block_bytes) begin
                                n_res.status = ST_NOBLOCK;
                            end else begin
                                // link of the head block is read this cycle
                                n_state = S_ALLOC;
                            end
                        end
                        FN_FREE: begin
                            if (r_pool_ready) begin
                                if (idx_oor) begin
                                    n_res.status = ST_NOTOWNER;
                                end else begin
                                    ram_we       = 1'b1;
                                    ram_waddr    = i_req.data.free_index[AW-1:0];
                                    ram_wdata    = r_head;
                                    n_head       = LW'(i_req.data.free_index);
                                    n_res.status = ST_OK;
                                end
                            end
                        end
                        FN_TEARDOWN: begin
                            if (r_pool_ready) begin
                                n_cur   = r_head;
                                n_seen  = '0;
                                n_state = S_WALK_CHK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP: begin
                // link block i to i+1, last block to the null marker
                ram_we    = 1'b1;
                ram_waddr = AW'(r_cnt);
                ram_wdata = setup_last ? NULL_LINK : LW'(r_cnt + 9'd1);
                if (setup_last) begin
                    n_pool_ready = 1'b1;
                    n_state      = S_DONE;
                    if (r_req > r_block_bytes) begin
                        n_head       = '0;
                        n_res.status = ST_NOBLOCK;
                    end else begin
                        // block 0 handed out straight away
                        n_head              = (live > 9'd1) ? LW'(1) : NULL_LINK;
                        n_res.granted_index = '0;
                        n_res.status        = ST_OK;
                    end
                end else begin
                    n_cnt = r_cnt + 9'd1;
                end
            end
            S_ALLOC: begin
                n_res.granted_index = GRANT_W'(r_head);
                n_res.status        = ST_OK;
                n_head              = ram_rdata;
                n_state             = S_DONE;
            end
            S_WALK_CHK: begin
                ram_raddr = r_cur[AW-1:0];
                if (r_seen < live && !cur_null) begin
                    n_state = S_WALK_RD;
                end else if (r_seen < live) begin
                    n_res.status = ST_INUSE;
                    n_state      = S_DONE;
                end else begin
                    n_pool_ready = 1'b0;
                    n_head       = NULL_LINK;
                    n_res.status = ST_OK;
                    n_state      = S_DONE;
                end
            end
            S_WALK_RD: begin
                n_cur   = ram_rdata;
                n_seen  = r_seen + 9'd1;
                n_state = S_WALK_CHK;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_ready <= 1'b0;
            r_head       <= NULL_LINK;
            r_cur        <= NULL_LINK;
            r_cnt        <= '0;
            r_seen       <= '0;
            r_req        <= '0;
            r_res        <= '{status: ST_OK, granted_index: '0};
            r_out_valid  <= 1'b0;
            r_out_data   <= '{status: ST_OK, granted_index: '0};
        end else begin
            r_state      <= n_state;
            r_pool_ready <= n_pool_ready;
            r_head       <= n_head;
            r_cur        <= n_cur;
            r_cnt        <= n_cnt;
            r_seen       <= n_seen;
            r_req        <= n_req;
            r_res        <= n_res;
            r_out_valid  <= n_out_valid;
            r_out_data   <= n_out_data;
        end
    end

    // a free of an owned block makes it the new head
    a_free_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req.data.func == FN_FREE && r_pool_ready && !idx_oor)
        |=> (r_head == $past(LW'(i_req.data.free_index))))
        else $error("free did not push the block onto the list");

    // set-up only runs on a pool that is not set up
    a_setup_no_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> !r_pool_ready)
        else $error("set-up running on a live pool");

    // the teardown walk never steps past the block count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_RD) |-> (r_seen < live))
        else $error("teardown walk overran the block count");

    // a new result only loads into an empty or draining output slot
    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> (r_state == S_DONE))
        else $error("result left the sequencer while the output slot was full");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the fixed block free-list allocator
`timescale 1ns / 1ps

module testbench;
    import fbfa_pkg::*;

    localparam int NBLK         = 256;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 2 * NBLK + 8;
    localparam int REPORT_LIMIT = 10;
    localparam int MAX_GAP      = 15;
    localparam int COUNT_MAX    = 511;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    fbfa_req_if req_bus();
    fbfa_rsp_if rsp_bus();

    fixed_block_free_list_allocator #(
        .MAX_BLOCKS (NBLK)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the pool and its registers
    logic [CNT_W-1:0]   link_mem [NBLK];
    logic [CNT_W-1:0]   free_head;
    logic               pool_up;
    logic [CNT_W-1:0]   count_reg;
    logic [BYTES_W-1:0] bytes_reg;
    int unsigned        setup_live;

    // blocks handed out and not yet returned, and results still owed
    int unsigned        held_blocks[$];
    t_rsp_beat          pending_outcomes[$];

    int unsigned        items_issued;
    int unsigned        fail_count;
    bit                 tx_burst;
    bit                 rx_burst;
    bit                 rsp_beat_taken;

    // clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] %s", $time, msg);
    endfunction

    function automatic int unsigned live_blocks();
        return (count_reg > NBLK) ? NBLK : int'(count_reg);
    endfunction

    // expected outcome of one operation, updating the shadow pool
    function automatic t_rsp_beat pool_outcome(input t_req_beat beat);
        t_rsp_beat   res;
        int unsigned live;
        int unsigned seen;
        int unsigned cur;
        res.status        = ST_BADSTATE;
        res.granted_index = '0;
        live = live_blocks();
        case (beat.func)
            FN_ALLOC: begin
                if (!pool_up && (live == 0 || bytes_reg == 0)) begin
                    res.status = ST_BADSTATE;
                end else begin
                    // first allocate links every block in ascending order
                    if (!pool_up) begin
                        for (int i = 0; i + 1 < live; i++)
                            link_mem[i] = CNT_W'(i + 1);
                        link_mem[live - 1] = CNT_W'(NBLK);
                        free_head  = '0;
                        pool_up    = 1'b1;
                        setup_live = live;
                    end
                    if (free_head >= NBLK || beat.request_bytes > bytes_reg) begin
                        res.status = ST_NOBLOCK;
                    end else begin
                        res.status        = ST_OK;
                        res.granted_index = free_head[GRANT_W-1:0];
                        free_head         = link_mem[free_head];
                    end
                end
            end
            FN_FREE: begin
                if (!pool_up) begin
                    res.status = ST_BADSTATE;
                end else if (beat.free_index >= live) begin
                    res.status = ST_NOTOWNER;
                end else begin
                    link_mem[beat.free_index] = free_head;
                    free_head  = beat.free_index[CNT_W-1:0];
                    res.status = ST_OK;
                end
            end
            FN_TEARDOWN: begin
                if (!pool_up) begin
                    res.status = ST_BADSTATE;
                end else begin
                    // bounded walk, a cyclic list still ends
                    seen = 0;
                    cur  = 32'(free_head);
                    while (seen < live && cur < NBLK) begin
                        seen++;
                        cur = 32'(link_mem[cur]);
                    end
                    if (seen < live) begin
                        res.status = ST_INUSE;
                    end else begin
                        pool_up    = 1'b0;
                        free_head  = CNT_W'(NBLK);
                        res.status = ST_OK;
                    end
                end
            end
            default: res.status = ST_BADSTATE;
        endcase
        return res;
    endfunction

    // present one operation beat and wait until it is taken
    task automatic issue(input logic [FUNC_W-1:0] fn, input logic [BYTES_W-1:0] req_bytes,
                         input logic [IDX_W-1:0] idx);
        t_req_beat   beat;
        t_rsp_beat   res;
        int unsigned gap;
        beat.func          = fn;
        beat.request_bytes = req_bytes;
        beat.free_index    = idx;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= beat;
        res = pool_outcome(beat);
        pending_outcomes.push_back(res);
        items_issued++;
        // keep track of which blocks the traffic owns
        if (fn == FN_ALLOC && res.status == ST_OK) begin
            held_blocks.push_back(32'(res.granted_index));
        end else if (fn == FN_FREE && res.status == ST_OK) begin
            for (int k = 0; k < held_blocks.size(); k++) begin
                if (held_blocks[k] == idx) begin
                    held_blocks.delete(k);
                    break;
                end
            end
        end else if (fn == FN_TEARDOWN && res.status == ST_OK) begin
            held_blocks.delete();
        end
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    // drop valid and wait for every owed result
    task automatic wait_idle();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_BLOCK_COUNT)
            count_reg = value[CNT_W-1:0];
        else
            bytes_reg = value;
    endtask

    // result checking
    always @(posedge i_clk) begin : result_check
        t_rsp_beat want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            rsp_beat_taken = 1'b1;
            if (pending_outcomes.size() == 0) begin
                note_failure($sformatf("unexpected result beat: status %0d, index %0d",
                                       rsp_bus.data.status, rsp_bus.data.granted_index));
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_bus.data.status !== want.status)
                    note_failure($sformatf("status mismatch: expected %0d, got %0d",
                                           want.status, rsp_bus.data.status));
                if (rsp_bus.data.granted_index !== want.granted_index)
                    note_failure($sformatf("granted index mismatch: expected %0d, got %0d",
                                           want.granted_index, rsp_bus.data.granted_index));
            end
        end
    end

    // result side back-pressure, redrawn after each beat
    initial begin : rsp_ready_drive
        int unsigned stall;
        stall = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_beat_taken) begin
                rsp_beat_taken = 1'b0;
                stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                rsp_bus.ready <= 1'b0;
                stall--;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // free, teardown and an unused code all refused before any set-up
    task automatic test_without_pool();
        issue(FN_FREE, '0, '0);
        issue(FN_TEARDOWN, '0, '0);
        issue(FN_UNUSED, '1, '1);
    endtask

    // set-up refused for a zero count and for a zero block size
    task automatic test_setup_refusal();
        wait_idle();
        write_reg(CFG_BLOCK_COUNT, '0);
        issue(FN_ALLOC, '0, '0);
        wait_idle();
        write_reg(CFG_BLOCK_COUNT, 16'd4);
        write_reg(CFG_BLOCK_BYTES, '0);
        issue(FN_ALLOC, '0, '0);
    endtask

    // four blocks: drain, overrun, range checks, refill, size change, release
    task automatic test_small_pool();
        wait_idle();
        write_reg(CFG_BLOCK_BYTES, 16'd100);
        issue(FN_ALLOC, 16'd101, '0);
        issue(FN_ALLOC, 16'd0, '0);
        issue(FN_ALLOC, 16'd100, '0);
        issue(FN_ALLOC, 16'd50, '0);
        issue(FN_ALLOC, 16'd50, '0);
        issue(FN_ALLOC, 16'd1, '0);
        issue(FN_TEARDOWN, '0, '0);
        issue(FN_FREE, '0, 16'd4);
        issue(FN_FREE, '0, 16'hFFFF);
        for (int b = 3; b >= 0; b--)
            issue(FN_FREE, '0, IDX_W'(b));
        // shrink the block size while the pool is live
        wait_idle();
        write_reg(CFG_BLOCK_BYTES, 16'd1);
        issue(FN_ALLOC, 16'd2, '0);
        issue(FN_ALLOC, 16'd1, '0);
        issue(FN_FREE, '0, IDX_W'(held_blocks[0]));
        issue(FN_TEARDOWN, '0, '0);
    endtask

    // count above the pool size, double free making the list cyclic
    task automatic test_oversized_pool();
        wait_idle();
        write_reg(CFG_BLOCK_COUNT, CFG_DAT_W'(COUNT_MAX));
        write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
        issue(FN_ALLOC, 16'hFFFF, '0);
        issue(FN_FREE, '0, IDX_W'(NBLK - 1));
        issue(FN_FREE, '0, IDX_W'(NBLK));
        issue(FN_TEARDOWN, '0, '0);
    endtask

    // phases of mostly well-formed allocate and free traffic with noise
    task automatic test_random_traffic();
        int unsigned          first;
        int unsigned          ops;
        int unsigned          pick;
        logic [CFG_DAT_W-1:0] value;
        logic [BYTES_W-1:0]   req;
        int unsigned          spare[$];
        first = items_issued;
        while (items_issued - first < RANDOM_ITEMS) begin
            // new setting per phase, extremes included
            wait_idle();
            case ($urandom_range(0, 19))
                0:       value = '0;
                1:       value = 16'd1;
                2:       value = CFG_DAT_W'(NBLK);
                3:       value = CFG_DAT_W'(COUNT_MAX);
                4:       value = CFG_DAT_W'($urandom_range(0, COUNT_MAX));
                default: value = CFG_DAT_W'($urandom_range(2, 16));
            endcase
            write_reg(CFG_BLOCK_COUNT, value);
            case ($urandom_range(0, 19))
                0:       value = '0;
                1:       value = 16'd1;
                2:       value = 16'hFFFF;
                3:       value = CFG_DAT_W'($urandom_range(0, 16'hFFFF));
                default: value = CFG_DAT_W'($urandom_range(1, 512));
            endcase
            write_reg(CFG_BLOCK_BYTES, value);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            ops = $urandom_range(10, 50);
            repeat (ops) begin
                pick = $urandom_range(0, 99);
                if (pick < 45 || (pick < 80 && held_blocks.size() == 0)) begin
                    case ($urandom_range(0, 7))
                        0:       req = BYTES_W'($urandom_range(0, 16'hFFFF));
                        1:       req = bytes_reg + 1'b1;
                        default: req = BYTES_W'($urandom_range(0, bytes_reg));
                    endcase
                    issue(FN_ALLOC, req, IDX_W'($urandom_range(0, 16'hFFFF)));
                end else if (pick < 80) begin
                    issue(FN_FREE, BYTES_W'($urandom_range(0, 16'hFFFF)),
                          IDX_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]));
                end else if (pick < 86) begin
                    issue(FN_FREE, BYTES_W'($urandom_range(0, 16'hFFFF)),
                          IDX_W'($urandom_range(0, 16'hFFFF)));
                end else if (pick < 90) begin
                    issue(FN_UNUSED, BYTES_W'($urandom_range(0, 16'hFFFF)),
                          IDX_W'($urandom_range(0, 16'hFFFF)));
                end else if (pick < 94) begin
                    issue(FN_TEARDOWN, BYTES_W'($urandom_range(0, 16'hFFFF)),
                          IDX_W'($urandom_range(0, 16'hFFFF)));
                end else if (pick < 97) begin
                    // register change while the pool may be live
                    wait_idle();
                    if ($urandom_range(0, 1) == 0) begin
                        value = ($urandom_range(0, 1) == 0)
                                ? CFG_DAT_W'($urandom_range(0, 16'hFFFF))
                                : CFG_DAT_W'($urandom_range(1, 512));
                        write_reg(CFG_BLOCK_BYTES, value);
                    end else begin
                        value = ($urandom_range(0, 3) == 0)
                                ? CFG_DAT_W'($urandom_range(0, COUNT_MAX))
                                : CFG_DAT_W'($urandom_range(0, 20));
                        write_reg(CFG_BLOCK_COUNT, value);
                    end
                end else begin
                    // in-range free, often a double free
                    issue(FN_FREE, '0, (live_blocks() == 0) ? '0
                                       : IDX_W'($urandom_range(0, live_blocks() - 1)));
                end
            end
            // hand everything back and release the pool
            spare = held_blocks;
            foreach (spare[j])
                issue(FN_FREE, '0, IDX_W'(spare[j]));
            issue(FN_TEARDOWN, '0, '0);
            if (pool_up) begin
                // blocks lost to shrinking or double frees: relink them all
                wait_idle();
                write_reg(CFG_BLOCK_COUNT, CFG_DAT_W'(setup_live));
                for (int b = 0; b < setup_live; b++)
                    issue(FN_FREE, '0, IDX_W'(b));
                issue(FN_TEARDOWN, '0, '0);
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // test sequence
    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_BLOCK_COUNT;
        i_cfg_data    = '0;
        req_bus.valid = 1'b0;
        req_bus.data  = '0;
        free_head     = CNT_W'(NBLK);
        pool_up       = 1'b0;
        count_reg     = BLOCK_COUNT_RST;
        bytes_reg     = BLOCK_BYTES_RST;
        setup_live    = 0;
        items_issued  = 0;
        fail_count    = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_without_pool();
        test_setup_refusal();
        test_small_pool();
        test_oversized_pool();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_outcomes.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_outcomes.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fbfa_pkg.sv
hw/rtl/fbfa_req_if.sv
hw/rtl/fbfa_rsp_if.sv
hw/rtl/fbfa_ram.sv
hw/rtl/fixed_block_free_list_allocator.sv
sim/testbench.sv
